// ===== rtl/core/lrs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrs_pkg
// shared types and constants of the lazy range-add range-sum tree
// ---------------------------------------------------------------------------
package lrs_pkg;

  localparam int MaxLenDefault = 1024;
  localparam int IdxW          = 11;
  localparam int ValW          = 32;
  localparam int SumW          = 64;

  typedef struct packed {
    logic            mode;
    logic [IdxW-1:0] range_low;
    logic [IdxW-1:0] range_high;
    logic [ValW-1:0] add_value;
  } in_item_t;

  typedef struct packed {
    logic [SumW-1:0] range_sum;
    logic            range_error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_LATCH,
    ST_SETTLE,
    ST_KID_L,
    ST_KID_R,
    ST_SPLIT,
    ST_POP,
    ST_CRD,
    ST_CLAT_L,
    ST_CSUM_L,
    ST_CWR
  } state_t;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_SUM = 1'b1;

endpackage : lrs_pkg
`default_nettype wire

// ===== rtl/core/lrs_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrs_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module lrs_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : lrs_ram
`default_nettype wire

// ===== rtl/core/lazy_range_add_range_sum_tree_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lazy_range_add_range_sum_tree_unit
// range add / range sum over a lazy segment tree held in two rams
// ---------------------------------------------------------------------------
// Usage: a request on in_* (valid/ready) either adds add_value to every element
// range_low..range_high (mode 0) or returns the 64-bit wrapped sum over that
// range (mode 1). One result per request leaves on out_* (valid/ready); a bad
// range gives range_error with a zero sum and leaves the tree untouched.
// cfg_we/cfg_wdata write length_in_use; write it only while no request is open.
// One shared multiply-add walks the tree node by node. An entered node goes
// through read, latch and settle, plus a step per child when its pending add
// is pushed to the children and a step that picks the child; a node left on
// the stack is popped, and each add combine is a pop followed by read, latch,
// sum and write steps. A bad range answers in the cycle after it is taken.
// in_ready is low while a request is at work and while its result waits, so
// one request is open at a time.
// Reset: a clearing pass zeroes both rams with in_ready low. A stalled
// receiver simply holds the result.
// ---------------------------------------------------------------------------
module lazy_range_add_range_sum_tree_unit #(
  parameter int MaxLen = lrs_pkg::MaxLenDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lrs_pkg::in_item_t     in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lrs_pkg::out_item_t         out_data,
  input  wire logic                  cfg_we,
  input  wire logic [lrs_pkg::IdxW-1:0] cfg_wdata
);

  localparam int Cap   = 1 << $clog2(MaxLen);
  localparam int Lvl   = $clog2(Cap);
  localparam int NodeN = 2 * Cap;
  localparam int NW    = $clog2(NodeN);
  localparam int PW    = Lvl + 1;          // span position width (1..Cap)
  localparam int SD    = 2 * Lvl + 2;
  localparam int SpW   = $clog2(SD);
  localparam int W     = lrs_pkg::SumW;
  localparam int IW    = lrs_pkg::IdxW;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    logic [PW-1:0] qlo;
    logic [PW-1:0] qhi;
    logic          comb;
  } frame_t;

  lrs_pkg::state_t state_r, state_nxt;
  frame_t stk_r [SD];
  logic [SpW-1:0] sp_r, sp_nxt;
  frame_t cur_r, cur_nxt;
  logic [IW-1:0] len_r;
  logic mode_r;
  logic [W-1:0] val_r;
  logic [W-1:0] acc_r, acc_nxt;
  logic [NW-1:0] clr_r;
  logic [W-1:0] s_r, p_r, s_nxt, p_nxt;
  logic [W-1:0] ls_r, ls_nxt;
  logic out_valid_r, out_valid_nxt;
  lrs_pkg::out_item_t out_r, out_nxt;

  // push request
  logic   push1, push2;
  frame_t pf1, pf2;

  // ram ports
  logic          s_we, p_we;
  logic [NW-1:0] s_wa, p_wa, s_ra, p_ra;
  logic [W-1:0]  s_wd, p_wd, s_rd, p_rd;

  lrs_ram #(.Width(W), .Depth(NodeN)) u_sum (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  lrs_ram #(.Width(W), .Depth(NodeN)) u_pend (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  // shared multiply-add unit: span * pending
  logic [PW-1:0] span;
  logic [W-1:0]  prod;
  assign prod = p_r * W'(span);

  logic [PW-1:0] mid;
  assign mid = cur_r.lo + ((cur_r.hi - cur_r.lo) >> 1);

  logic [NW-1:0] left_node, right_node;
  assign left_node  = {cur_r.node[NW-2:0], 1'b0};
  assign right_node = {cur_r.node[NW-2:0], 1'b1};

  logic [IW-1:0] eff_len;
  assign eff_len = (len_r > IW'(MaxLen)) ? IW'(MaxLen) : len_r;
  logic bad;
  assign bad = (in_data.range_low == '0) || (in_data.range_low > in_data.range_high)
               || (in_data.range_high > eff_len);

  logic leaf, full;
  assign leaf = (cur_r.lo == cur_r.hi);
  assign full = (cur_r.lo == cur_r.qlo) && (cur_r.hi == cur_r.qhi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrs_pkg::ST_CLEAR;
      clr_r       <= '0;
      sp_r        <= '0;
      len_r       <= IW'(1024);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == lrs_pkg::ST_CLEAR) clr_r <= clr_r + NW'(1);
      if (cfg_we) len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    acc_r <= acc_nxt;
    s_r   <= s_nxt;
    p_r   <= p_nxt;
    ls_r  <= ls_nxt;
    out_r <= out_nxt;
    if (in_valid && in_ready) begin
      mode_r <= in_data.mode;
      val_r  <= W'(signed'(in_data.add_value));
    end
    if (push1) stk_r[sp_r] <= pf1;
    if (push2) stk_r[sp_r + SpW'(1)] <= pf2;
  end

  assign in_ready  = (state_r == lrs_pkg::ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    s_nxt         = s_r;
    p_nxt         = p_r;
    ls_nxt        = ls_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    push1 = 1'b0; push2 = 1'b0; pf1 = cur_r; pf2 = cur_r;
    s_we = 1'b0; p_we = 1'b0;
    s_wa = cur_r.node; p_wa = cur_r.node; s_wd = '0; p_wd = '0;
    s_ra = cur_r.node; p_ra = cur_r.node;
    span = cur_r.hi - cur_r.lo + PW'(1);

    unique case (state_r)
      lrs_pkg::ST_CLEAR: begin
        s_we = 1'b1; p_we = 1'b1; s_wa = clr_r; p_wa = clr_r;
        if (clr_r == NW'(NodeN - 1)) state_nxt = lrs_pkg::ST_IDLE;
      end
      lrs_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          acc_nxt = '0;
          if (bad) begin
            out_nxt = '{range_sum: '0, range_error: 1'b1};
            out_valid_nxt = 1'b1;
          end else begin
            cur_nxt = '{node: NW'(1), lo: PW'(1), hi: PW'(Cap),
                        qlo: PW'(in_data.range_low), qhi: PW'(in_data.range_high),
                        comb: 1'b0};
            sp_nxt = '0;
            state_nxt = lrs_pkg::ST_RD;
          end
        end
      end
      lrs_pkg::ST_RD: state_nxt = lrs_pkg::ST_LATCH;  // address presented
      lrs_pkg::ST_LATCH: begin
        s_nxt = s_rd; p_nxt = p_rd;
        state_nxt = lrs_pkg::ST_SETTLE;
      end
      lrs_pkg::ST_SETTLE: begin
        // left child pending read goes out early for the push-down
        p_ra = left_node;
        if (full) begin
          // covered node: add joins its pending, sum takes the settled value
          if (mode_r == lrs_pkg::MODE_ADD) begin
            p_we = 1'b1; p_wd = p_r + val_r;
          end else begin
            acc_nxt = acc_r + s_r + prod;
          end
          state_nxt = lrs_pkg::ST_POP;
        end else if (leaf) begin
          state_nxt = lrs_pkg::ST_POP;
        end else begin
          s_we = 1'b1; s_wd = s_r + prod;
          p_we = 1'b1; p_wd = '0;
          state_nxt = (p_r != '0) ? lrs_pkg::ST_KID_L : lrs_pkg::ST_SPLIT;
        end
      end
      lrs_pkg::ST_KID_L: begin
        p_we = 1'b1; p_wa = left_node; p_wd = p_rd + p_r;
        p_ra = right_node;
        state_nxt = lrs_pkg::ST_KID_R;
      end
      lrs_pkg::ST_KID_R: begin
        p_we = 1'b1; p_wa = right_node; p_wd = p_rd + p_r;
        state_nxt = lrs_pkg::ST_SPLIT;
      end
      lrs_pkg::ST_SPLIT: begin
        // an add leaves a combine frame under its children
        if (mode_r == lrs_pkg::MODE_ADD) begin
          pf1 = cur_r; pf1.comb = 1'b1;
          push1 = 1'b1;
        end
        if (cur_r.qhi <= mid) begin
          cur_nxt = '{node: left_node, lo: cur_r.lo, hi: mid,
                      qlo: cur_r.qlo, qhi: cur_r.qhi, comb: 1'b0};
        end else if (mid + PW'(1) <= cur_r.qlo) begin
          cur_nxt = '{node: right_node, lo: mid + PW'(1), hi: cur_r.hi,
                      qlo: cur_r.qlo, qhi: cur_r.qhi, comb: 1'b0};
        end else begin
          // left side is walked now, right side waits on the stack
          if (mode_r == lrs_pkg::MODE_ADD) begin
            pf2 = '{node: right_node, lo: mid + PW'(1), hi: cur_r.hi,
                    qlo: mid + PW'(1), qhi: cur_r.qhi, comb: 1'b0};
            push2 = 1'b1;
          end else begin
            pf1 = '{node: right_node, lo: mid + PW'(1), hi: cur_r.hi,
                    qlo: mid + PW'(1), qhi: cur_r.qhi, comb: 1'b0};
            push1 = 1'b1;
          end
          cur_nxt = '{node: left_node, lo: cur_r.lo, hi: mid,
                      qlo: cur_r.qlo, qhi: mid, comb: 1'b0};
        end
        sp_nxt = sp_r + SpW'(push1) + SpW'(push2);
        state_nxt = lrs_pkg::ST_RD;
      end
      lrs_pkg::ST_POP: begin
        if (sp_r == '0) begin
          out_nxt = '{range_sum: (mode_r == lrs_pkg::MODE_SUM) ? acc_r : '0,
                      range_error: 1'b0};
          out_valid_nxt = 1'b1;
          state_nxt = lrs_pkg::ST_IDLE;
        end else begin
          cur_nxt = stk_r[sp_r - SpW'(1)];
          sp_nxt  = sp_r - SpW'(1);
          state_nxt = stk_r[sp_r - SpW'(1)].comb ? lrs_pkg::ST_CRD : lrs_pkg::ST_RD;
        end
      end
      lrs_pkg::ST_CRD: begin
        s_ra = left_node; p_ra = left_node;
        state_nxt = lrs_pkg::ST_CLAT_L;
      end
      lrs_pkg::ST_CLAT_L: begin
        s_nxt = s_rd; p_nxt = p_rd;
        s_ra = right_node; p_ra = right_node;
        state_nxt = lrs_pkg::ST_CSUM_L;
      end
      lrs_pkg::ST_CSUM_L: begin
        // child total is its sum plus its pending over its span
        span   = mid - cur_r.lo + PW'(1);
        ls_nxt = s_r + prod;
        s_nxt  = s_rd; p_nxt = p_rd;
        state_nxt = lrs_pkg::ST_CWR;
      end
      lrs_pkg::ST_CWR: begin
        span = cur_r.hi - mid;
        s_we = 1'b1; s_wd = ls_r + s_r + prod;
        state_nxt = lrs_pkg::ST_POP;
      end
      default: state_nxt = lrs_pkg::ST_IDLE;
    endcase
  end

endmodule : lazy_range_add_range_sum_tree_unit
`default_nettype wire
